// ===== src/pru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the PNG row unfilter (8-bit RGB) core.
// ----------------------------------------------------------------------------
package pru_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int BPP_DEFAULT       = 3;

   // Rows per image saturate here; row counter and height register follow it
   localparam int HEIGHT_LIMIT = 4096;
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
   localparam int HEIGHT_W     = $clog2(HEIGHT_LIMIT + 1);

   localparam int REG_W       = 13;
   localparam int CSR_INDEX_W = 4;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_COUNT_W    = $clog2(RSP_FIFO_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 0,
      CSR_IMAGE_HEIGHT = 1
   } csr_index_type;

   typedef enum logic [2:0] {
      FILTER_NONE    = 3'd0,
      FILTER_SUB     = 3'd1,
      FILTER_UP      = 3'd2,
      FILTER_AVERAGE = 3'd3,
      FILTER_PAETH   = 3'd4
   } filter_type;

   localparam logic [7:0] FILTER_CODE_MAX = 8'd4;

   // One accepted request on its way to the predict stage
   typedef struct packed {
      logic       valid;
      logic       data;       // colour byte; clear means filter byte
      logic       bad;        // filter byte out of range
      logic       first_row;
      logic       last;
      filter_type filter;
      logic [7:0] raw;
   } pru_issue_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       end_of_image;
      logic       bad_filter;
   } pru_result_type;

endpackage

// ===== src/pru_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pru_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pru_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ctrl
// Configuration registers, row and column tracking, filter byte decode and
// row memory read issue. Registers each request into the predict stage.
// ----------------------------------------------------------------------------
module pru_ctrl import pru_pkg::*; #(
   parameter int  MAX_WIDTH       = MAX_WIDTH_DEFAULT,
   parameter int  BYTES_PER_PIXEL = BPP_DEFAULT,
   localparam int ROW_BYTES       = MAX_WIDTH * BYTES_PER_PIXEL,
   localparam int ADDR_W          = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1,
   localparam int LANE_W          = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_write_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_raw_byte,
   output logic                   restart,
   output logic                   ram_rd_en,
   output logic [ADDR_W-1:0]      ram_rd_addr,
   output pru_issue_type          issue,
   output logic [ADDR_W-1:0]      issue_addr,
   output logic [LANE_W-1:0]      issue_lane
);

   localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
   localparam int STRIDE_W = $clog2(ROW_BYTES + 1);

   logic                accept;
   logic                hit_width;
   logic                hit_height;
   logic [WIDTH_W-1:0]  width_eff;
   logic [STRIDE_W-1:0] stride_value;
   logic [HEIGHT_W-1:0] height_eff;
   logic                row_end;
   logic                last_row;

   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic                data_phase_ff, data_phase_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [LANE_W-1:0]   lane_ff, lane_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   filter_type          filter_ff, filter_in;
   logic                error_ff, error_in;
   pru_issue_type       issue_ff, issue_in;
   logic [ADDR_W-1:0]   issue_addr_ff, issue_addr_in;
   logic [LANE_W-1:0]   issue_lane_ff, issue_lane_in;

   assign accept     = req_valid && !req_stall;
   assign hit_width  = csr_write_enable && (csr_index == CSR_IMAGE_WIDTH);
   assign hit_height = csr_write_enable && (csr_index == CSR_IMAGE_HEIGHT);
   assign restart    = hit_width || hit_height;

   // Clamp register values into the working range at write time
   assign width_eff = (csr_write_data == '0) ? WIDTH_W'(1) :
                      (32'(csr_write_data) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) :
                      WIDTH_W'(csr_write_data);
   assign stride_value = STRIDE_W'(32'(width_eff) * BYTES_PER_PIXEL);
   assign height_eff = (csr_write_data == '0) ? HEIGHT_W'(1) :
                       (32'(csr_write_data) > HEIGHT_LIMIT) ? HEIGHT_W'(HEIGHT_LIMIT) :
                       HEIGHT_W'(csr_write_data);

   assign row_end  = (STRIDE_W'(pos_ff) + STRIDE_W'(1)) >= stride_ff;
   assign last_row = (HEIGHT_W'(row_ff) + HEIGHT_W'(1)) >= height_ff;

   always_comb begin
      stride_in          = stride_ff;
      height_in          = height_ff;
      data_phase_in      = data_phase_ff;
      pos_in             = pos_ff;
      lane_in            = lane_ff;
      row_in             = row_ff;
      filter_in          = filter_ff;
      error_in           = error_ff;
      issue_in           = '0;
      issue_in.raw       = req_raw_byte;
      issue_in.filter    = filter_ff;
      issue_in.first_row = (row_ff == '0);
      issue_addr_in      = pos_ff;
      issue_lane_in      = lane_ff;
      if (restart) begin
         if (hit_width) begin
            stride_in = stride_value;
         end
         if (hit_height) begin
            height_in = height_eff;
         end
         data_phase_in = 1'b0;
         row_in        = '0;
         filter_in     = FILTER_NONE;
      end else if (accept && !error_ff) begin
         issue_in.valid = 1'b1;
         if (!data_phase_ff) begin
            if (req_raw_byte > FILTER_CODE_MAX) begin
               error_in     = 1'b1;
               issue_in.bad = 1'b1;
            end else begin
               filter_in     = filter_type'(req_raw_byte[2:0]);
               data_phase_in = 1'b1;
               pos_in        = '0;
               lane_in       = '0;
            end
         end else begin
            issue_in.data = 1'b1;
            issue_in.last = row_end && last_row;
            if (row_end) begin
               data_phase_in = 1'b0;
               row_in        = last_row ? '0 : row_ff + ROW_W'(1);
            end else begin
               pos_in  = pos_ff + ADDR_W'(1);
               lane_in = (lane_ff == LANE_W'(BYTES_PER_PIXEL - 1)) ? '0 :
                         lane_ff + LANE_W'(1);
            end
         end
      end
   end

   // Up byte for this position was written at least two requests ago
   // (a filter byte always separates rows), so no forwarding is needed.
   assign ram_rd_en   = accept && !error_ff && data_phase_ff && !restart;
   assign ram_rd_addr = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff     <= STRIDE_W'(BYTES_PER_PIXEL);
         height_ff     <= HEIGHT_W'(1);
         data_phase_ff <= 1'b0;
         pos_ff        <= '0;
         lane_ff       <= '0;
         row_ff        <= '0;
         filter_ff     <= FILTER_NONE;
         error_ff      <= 1'b0;
         issue_ff      <= '0;
      end else begin
         stride_ff     <= stride_in;
         height_ff     <= height_in;
         data_phase_ff <= data_phase_in;
         pos_ff        <= pos_in;
         lane_ff       <= lane_in;
         row_ff        <= row_in;
         filter_ff     <= filter_in;
         error_ff      <= error_in;
         issue_ff      <= issue_in;
      end
      issue_addr_ff <= issue_addr_in;
      issue_lane_ff <= issue_lane_in;
   end

   assign issue      = issue_ff;
   assign issue_addr = issue_addr_ff;
   assign issue_lane = issue_lane_ff;

endmodule

// ===== src/pru_predict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_predict
// Predict stage: takes the up byte from the row memory, applies the row
// filter, writes the reconstructed byte back and keeps the per-lane history.
// ----------------------------------------------------------------------------
module pru_predict import pru_pkg::*; #(
   parameter int  MAX_WIDTH       = MAX_WIDTH_DEFAULT,
   parameter int  BYTES_PER_PIXEL = BPP_DEFAULT,
   localparam int ROW_BYTES       = MAX_WIDTH * BYTES_PER_PIXEL,
   localparam int ADDR_W          = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1,
   localparam int LANE_W          = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  pru_issue_type     issue,
   input  logic [ADDR_W-1:0] issue_addr,
   input  logic [LANE_W-1:0] issue_lane,
   input  logic [7:0]        ram_rd_data,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [7:0]        ram_wr_data,
   output logic              result_push,
   output pru_result_type    result
);

   logic [7:0] left_ff   [BYTES_PER_PIXEL];
   logic [7:0] corner_ff [BYTES_PER_PIXEL];

   logic [7:0]        left_byte;
   logic [7:0]        up_byte;
   logic [7:0]        corner_byte;
   logic [8:0]        pair_sum;
   logic signed [9:0] s_left, s_up, s_corner;
   logic signed [9:0] dist_a_raw, dist_b_raw, dist_c_raw;
   logic signed [9:0] dist_a, dist_b, dist_c;
   logic [7:0]        paeth_byte;
   logic [7:0]        pred;
   logic [7:0]        value;

   assign left_byte   = left_ff[issue_lane];
   assign corner_byte = corner_ff[issue_lane];
   assign up_byte     = issue.first_row ? 8'd0 : ram_rd_data;

   assign pair_sum = {1'b0, left_byte} + {1'b0, up_byte};

   // Paeth distances from p = a + b - c, reduced to differences of inputs
   assign s_left     = signed'({2'b00, left_byte});
   assign s_up       = signed'({2'b00, up_byte});
   assign s_corner   = signed'({2'b00, corner_byte});
   assign dist_a_raw = s_up - s_corner;
   assign dist_b_raw = s_left - s_corner;
   assign dist_c_raw = s_left + s_up - s_corner - s_corner;
   assign dist_a     = (dist_a_raw < 0) ? -dist_a_raw : dist_a_raw;
   assign dist_b     = (dist_b_raw < 0) ? -dist_b_raw : dist_b_raw;
   assign dist_c     = (dist_c_raw < 0) ? -dist_c_raw : dist_c_raw;

   always_comb begin
      if (dist_a <= dist_b && dist_a <= dist_c) begin
         paeth_byte = left_byte;
      end else if (dist_b <= dist_c) begin
         paeth_byte = up_byte;
      end else begin
         paeth_byte = corner_byte;
      end
   end

   always_comb begin
      case (issue.filter)
         FILTER_SUB:     pred = left_byte;
         FILTER_UP:      pred = up_byte;
         FILTER_AVERAGE: pred = pair_sum[8:1];
         FILTER_PAETH:   pred = paeth_byte;
         default:        pred = 8'd0;
      endcase
   end

   assign value = issue.raw + pred;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
            left_ff[i]   <= 8'd0;
            corner_ff[i] <= 8'd0;
         end
      end else if (issue.valid) begin
         if (issue.data) begin
            left_ff[issue_lane]   <= value;
            corner_ff[issue_lane] <= up_byte;
         end else if (!issue.bad) begin
            // good filter byte: a fresh row starts with empty history
            for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
               left_ff[i]   <= 8'd0;
               corner_ff[i] <= 8'd0;
            end
         end
      end
   end

   assign ram_wr_en   = issue.valid && issue.data;
   assign ram_wr_addr = issue_addr;
   assign ram_wr_data = value;

   assign result_push         = issue.valid && (issue.data || issue.bad);
   assign result.pixel_value  = issue.bad ? 8'd0 : value;
   assign result.end_of_image = issue.last;
   assign result.bad_filter   = issue.bad;

endmodule

// ===== src/pru_rsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_rsp_fifo
// Small response queue that decouples the predict stage from rsp_stall.
// ----------------------------------------------------------------------------
module pru_rsp_fifo import pru_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pru_result_type         push_data,
   input  logic                   pop,
   output pru_result_type         head,
   output logic [RSP_COUNT_W-1:0] fill
);

   pru_result_type         entry_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_COUNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + RSP_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + RSP_PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + RSP_COUNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - RSP_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head = entry_ff[rd_ptr_ff];
   assign fill = fill_ff;

endmodule

// ===== src/png_row_unfilter_rgb8_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_rgb8_core
// PNG scanline reconstruction for 8-bit RGB: filter byte decode, None / Sub /
// Up / Average / Paeth prediction against a stored previous row.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    req_raw_byte
//   rsp      out        rsp_valid/stall    rsp_pixel_value, end_of_image, bad_filter
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// One request per cycle sustained while req_stall stays low. A colour byte
// reaches rsp through the registered row memory read and issue register, then
// through the predict stage into the response queue. The single read port of
// the row memory and the left-history loop in the predict stage set that rate.
// Synchronous reset clears control state; the row memory needs no clearing pass.
// req_stall rises when queue fill plus an issued request reaches three of four.
// ----------------------------------------------------------------------------
module png_row_unfilter_rgb8_core import pru_pkg::*; #(
   parameter int MAX_WIDTH       = MAX_WIDTH_DEFAULT,
   parameter int BYTES_PER_PIXEL = BPP_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_raw_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_pixel_value,
   output logic                   rsp_end_of_image,
   output logic                   rsp_bad_filter,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_write_data
);

   localparam int ROW_BYTES = MAX_WIDTH * BYTES_PER_PIXEL;
   localparam int ADDR_W    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int LANE_W    = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;

   logic                   restart;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [7:0]             ram_rd_data;
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [7:0]             ram_wr_data;
   pru_issue_type          issue;
   logic [ADDR_W-1:0]      issue_addr;
   logic [LANE_W-1:0]      issue_lane;
   logic                   result_push;
   pru_result_type         result;
   pru_result_type         head;
   logic [RSP_COUNT_W-1:0] fill;
   logic                   rsp_pop;

   pru_ctrl #(
      .MAX_WIDTH       (MAX_WIDTH),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_byte     (req_raw_byte),
      .restart          (restart),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .issue            (issue),
      .issue_addr       (issue_addr),
      .issue_lane       (issue_lane)
   );

   pru_ram #(
      .WIDTH (8),
      .DEPTH (ROW_BYTES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pru_predict #(
      .MAX_WIDTH       (MAX_WIDTH),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_predict (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .issue       (issue),
      .issue_addr  (issue_addr),
      .issue_lane  (issue_lane),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .result_push (result_push),
      .result      (result)
   );

   pru_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .pop       (rsp_pop),
      .head      (head),
      .fill      (fill)
   );

   // Hold requests while the queue could not absorb everything in flight
   assign req_stall = reset ||
                      ((fill + RSP_COUNT_W'(issue.valid)) >=
                       RSP_COUNT_W'(RSP_FIFO_DEPTH - 1));

   assign rsp_valid        = (fill != '0);
   assign rsp_pop          = rsp_valid && !rsp_stall;
   assign rsp_pixel_value  = head.pixel_value;
   assign rsp_end_of_image = head.end_of_image;
   assign rsp_bad_filter   = head.bad_filter;

endmodule

// ===== src/pru_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_checker
// Port-level checks on the response channel of the row unfilter core.
// ----------------------------------------------------------------------------
module pru_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_pixel_value,
   input logic       rsp_end_of_image,
   input logic       rsp_bad_filter
);

   logic bad_taken_ff;

   // Latch once the error response has been taken
   always_ff @(posedge clock) begin
      if (reset) begin
         bad_taken_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_bad_filter) begin
         bad_taken_ff <= 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_value) &&
         $stable(rsp_end_of_image) && $stable(rsp_bad_filter))
      else $error("stalled response changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_filter |-> rsp_pixel_value == 8'd0 && !rsp_end_of_image)
      else $error("error response carries pixel data or end of image");

   assert property (@(posedge clock) disable iff (reset)
      bad_taken_ff |-> !rsp_valid)
      else $error("response issued after the error response");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response pending straight after reset");

endmodule

bind png_row_unfilter_rgb8_core pru_checker u_pru_checker (.*);

// ===== tb/png_row_unfilter_rgb8_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_rgb8_core_test
// Self-checking bench for the PNG row unfilter core. A directed table walks
// every filter, the row and image edges and register restarts. Random images
// of mixed sizes follow under changing idle patterns, then oversized register
// values, and last a bad filter byte with the latched error.
// Every accepted request runs through a local predictor, and each response
// is compared field by field with the oldest expected pixel.
// ----------------------------------------------------------------------------
module png_row_unfilter_rgb8_core_test;
   import pru_pkg::*;

   localparam int          RESET_CYCLES       = 12;
   localparam int          PIPE_SETTLE_CYCLES = 4;
   localparam int          RSP_HOLD_CYCLES    = 60;
   localparam int unsigned CYCLE_LIMIT        = 400_000;
   localparam int unsigned RANDOM_PER_MODE    = 150;
   localparam int unsigned ROW_BYTES_MAX      = MAX_WIDTH_DEFAULT * BPP_DEFAULT;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 4'd7;
   localparam bit                     ROW_BYTE         = 1'b0;
   localparam bit                     ROW_WRITE        = 1'b1;
   localparam pru_result_type         NO_RESULT        = '0;

   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] index;
      logic [REG_W-1:0]       data;
      logic [7:0]             raw;
      bit                     typed;
      pru_result_type         want;
   } step_row;

   bit                     clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_raw_byte     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [7:0]             rsp_pixel_value;
   logic                   rsp_end_of_image;
   logic                   rsp_bad_filter;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [REG_W-1:0]       csr_write_data   = '0;

   // predictor state, mirrors the core after reset
   logic [REG_W-1:0] width_reg        = 13'd1;
   logic [REG_W-1:0] height_reg       = 13'd1;
   int unsigned      column_count     = 0;
   int unsigned      row_index        = 0;
   filter_type       current_filter   = FILTER_NONE;
   logic [7:0]       left_bytes [BPP_DEFAULT];
   logic [7:0]       corner_bytes [BPP_DEFAULT];
   logic [7:0]       previous_row_bytes [ROW_BYTES_MAX];
   bit               error_latched    = 1'b0;

   pru_result_type   pending_pixels [$];
   bit               typed_active     = 1'b0;
   pru_result_type   typed_result     = '0;
   int unsigned      mismatch_count   = 0;
   int unsigned      cycles_run       = 0;
   int unsigned      sender_idle_pct  = 0;
   int unsigned      receiver_idle_pct = 0;
   int unsigned      hold_requests    = 0;
   int unsigned      holds_served     = 0;
   int unsigned      hold_left        = 0;

   step_row directed_steps [$] = '{
      // single-pixel image after reset, no filter
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'(FILTER_NONE), 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0}},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'hA5, 1'b1, '{8'hA5, 1'b1, 1'b0}},
      '{ROW_WRITE, CSR_UNUSED_INDEX, 13'd5, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_IMAGE_WIDTH,  13'd0, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_IMAGE_HEIGHT, 13'd2, 8'h00, 1'b0, NO_RESULT},
      // Up on the first row sees zero above; Paeth on the second
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'(FILTER_UP), 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd10,  1'b1, '{8'd10, 1'b0, 1'b0}},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd20,  1'b1, '{8'd20, 1'b0, 1'b0}},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd30,  1'b1, '{8'd30, 1'b0, 1'b0}},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'(FILTER_PAETH), 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd250, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd0,   1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd255, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_IMAGE_WIDTH,  13'd2, 8'h00, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_IMAGE_HEIGHT, 13'd2, 8'h00, 1'b0, NO_RESULT},
      // Sub wraps modulo 256; Average then sums past 8 bits
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'(FILTER_SUB), 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd255, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd255, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd255, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd200, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd201, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd202, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'(FILTER_AVERAGE), 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd255, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd254, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd1,   1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd0,   1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd128, 1'b0, NO_RESULT},
      '{ROW_BYTE,  CSR_IMAGE_WIDTH,  13'd0, 8'd3,   1'b0, NO_RESULT}
   };

   png_row_unfilter_rgb8_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_byte     (req_raw_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_end_of_image (rsp_end_of_image),
      .rsp_bad_filter   (rsp_bad_filter),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned clamp_size(logic [REG_W-1:0] value, int unsigned upper);
      if (value == 0) return 1;
      if (value > upper) return upper;
      return 32'(value);
   endfunction

   function automatic void restart_image();
      column_count   = 0;
      row_index      = 0;
      current_filter = FILTER_NONE;
      foreach (left_bytes[i]) begin
         left_bytes[i]   = '0;
         corner_bytes[i] = '0;
      end
   endfunction

   function automatic void apply_register_write(logic [CSR_INDEX_W-1:0] index,
                                                logic [REG_W-1:0] value);
      if (index == CSR_IMAGE_WIDTH) width_reg = value;
      else if (index == CSR_IMAGE_HEIGHT) height_reg = value;
      else return;
      restart_image();
   endfunction

   // Returns 1 for a pixel or the error; bad and post-error bytes keep the row state
   function automatic bit predict_pixel(logic [7:0] raw, output pru_result_type res);
      int unsigned stride, x, lane;
      int          a, b, c, p, pa, pb, pc;
      logic [7:0]  left, up, corner, pred, value;
      logic [8:0]  sum;
      res = '0;
      if (error_latched) return 1'b0;
      if (column_count == 0) begin
         if (raw > FILTER_CODE_MAX) begin
            error_latched  = 1'b1;
            res.bad_filter = 1'b1;
            return 1'b1;
         end
         current_filter = filter_type'(raw[2:0]);
         column_count   = 1;
         foreach (left_bytes[i]) begin
            left_bytes[i]   = '0;
            corner_bytes[i] = '0;
         end
         return 1'b0;
      end
      stride = clamp_size(width_reg, MAX_WIDTH_DEFAULT) * BPP_DEFAULT;
      x      = column_count - 1;
      lane   = x % BPP_DEFAULT;
      left   = left_bytes[lane];
      corner = corner_bytes[lane];
      up     = (row_index != 0) ? previous_row_bytes[x] : 8'd0;
      case (current_filter)
         FILTER_SUB:     pred = left;
         FILTER_UP:      pred = up;
         FILTER_AVERAGE: begin
            sum  = {1'b0, left} + {1'b0, up};
            pred = sum[8:1];
         end
         FILTER_PAETH:   begin
            a  = left;
            b  = up;
            c  = corner;
            p  = a + b - c;
            pa = (p > a) ? p - a : a - p;
            pb = (p > b) ? p - b : b - p;
            pc = (p > c) ? p - c : c - p;
            if (pa <= pb && pa <= pc) pred = left;
            else if (pb <= pc) pred = up;
            else pred = corner;
         end
         default:        pred = 8'd0;
      endcase
      value                 = raw + pred;
      left_bytes[lane]      = value;
      corner_bytes[lane]    = up;
      previous_row_bytes[x] = value;
      res.pixel_value       = value;
      if (x + 1 >= stride) begin
         column_count = 0;
         if (row_index + 1 >= clamp_size(height_reg, HEIGHT_LIMIT)) begin
            res.end_of_image = 1'b1;
            row_index        = 0;
         end else begin
            row_index++;
         end
      end else begin
         column_count++;
      end
      return 1'b1;
   endfunction

   // Receiver: random stall, or a long hold when one is asked for
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_stall    <= 1'b1;
         hold_left    <= RSP_HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      pru_result_type predicted;
      pru_result_type wanted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $error("rsp_pixel_value: expected no response, got %0d", rsp_pixel_value);
               mismatch_count++;
            end else begin
               wanted = pending_pixels.pop_front();
               if (rsp_pixel_value !== wanted.pixel_value) begin
                  $error("rsp_pixel_value: expected %0d, got %0d",
                         wanted.pixel_value, rsp_pixel_value);
                  mismatch_count++;
               end
               if (rsp_end_of_image !== wanted.end_of_image) begin
                  $error("rsp_end_of_image: expected %0d, got %0d",
                         wanted.end_of_image, rsp_end_of_image);
                  mismatch_count++;
               end
               if (rsp_bad_filter !== wanted.bad_filter) begin
                  $error("rsp_bad_filter: expected %0d, got %0d",
                         wanted.bad_filter, rsp_bad_filter);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (predict_pixel(req_raw_byte, predicted))
               pending_pixels.push_back(typed_active ? typed_result : predicted);
         end
      end
   end

   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] raw);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_raw_byte <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the sender until every pixel is back and the pipe has emptied
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (PIPE_SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [REG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      apply_register_write(index, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Well-formed rows: a filter byte 0..4, then row_bytes colour bytes
   task automatic stream_bytes(input int unsigned count, input int unsigned row_bytes);
      for (int unsigned k = 0; k < count; k++) begin
         if (k % (row_bytes + 1) == 0) send_byte(8'($urandom_range(0, 4)));
         else send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_random_images(input int unsigned target, input bit with_hold);
      int unsigned sent_here;
      int unsigned width_val;
      int unsigned height_val;
      int unsigned row_bytes;
      int unsigned count;
      int unsigned pick;
      bit          hold_now;
      sent_here = 0;
      while (sent_here < target) begin
         drain_results();
         hold_now = with_hold && sent_here == 0;
         pick     = $urandom_range(0, 9);
         if (hold_now) width_val = 8;
         else if (pick == 0) width_val = 0;
         else if (pick == 1) width_val = $urandom_range(9, 40);
         else width_val = $urandom_range(1, 8);
         if (hold_now) height_val = 4;
         else if ($urandom_range(0, 7) == 0) height_val = 0;
         else height_val = $urandom_range(1, 4);
         write_register(CSR_IMAGE_WIDTH, REG_W'(width_val));
         write_register(CSR_IMAGE_HEIGHT, REG_W'(height_val));
         row_bytes = clamp_size(REG_W'(width_val), MAX_WIDTH_DEFAULT) * BPP_DEFAULT;
         count     = clamp_size(REG_W'(height_val), HEIGHT_LIMIT) * (row_bytes + 1)
                     * $urandom_range(1, 2);
         // break off part-way now and then; the next write restarts the image
         if (!hold_now && $urandom_range(0, 5) == 0) count = $urandom_range(1, count);
         if (hold_now) hold_requests++;
         stream_bytes(count, row_bytes);
         sent_here += count;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 19;
      receiver_idle_pct = 52;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_write) begin
            drain_results();
            write_register(directed_steps[i].index, directed_steps[i].data);
         end else begin
            typed_active = directed_steps[i].typed;
            typed_result = directed_steps[i].want;
            send_byte(directed_steps[i].raw);
            typed_active = 1'b0;
         end
      end

      run_random_images(RANDOM_PER_MODE, 1'b1);
      sender_idle_pct   = 52;
      receiver_idle_pct = 19;
      run_random_images(RANDOM_PER_MODE, 1'b0);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random_images(RANDOM_PER_MODE, 1'b1);

      // oversized registers clamp: run well into the clamped row
      drain_results();
      write_register(CSR_IMAGE_WIDTH, 13'd8191);
      write_register(CSR_IMAGE_HEIGHT, 13'd8191);
      stream_bytes(1 + 61, ROW_BYTES_MAX);

      // bad filter type last: the error latches and all later requests drop
      drain_results();
      write_register(CSR_IMAGE_HEIGHT, 13'd1);
      send_byte(8'($urandom_range(5, 255)));
      for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 255)));
      drain_results();
      write_register(CSR_IMAGE_WIDTH, 13'd2);
      for (int i = 0; i < 7; i++) send_byte(8'($urandom_range(0, 4)));
      drain_results();

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pru_pkg.sv
src/pru_ram.sv
src/pru_ctrl.sv
src/pru_predict.sv
src/pru_rsp_fifo.sv
src/png_row_unfilter_rgb8_core.sv
src/pru_checker.sv
tb/png_row_unfilter_rgb8_core_test.sv
